FILE: hw/rtl/fmdv_pkg.sv
package fmdv_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_CARRIER_INC  = 3'd0;
  localparam logic [2:0] CFG_MOD_INC      = 3'd1;
  localparam logic [2:0] CFG_ATTACK_SHIFT = 3'd2;
  localparam logic [2:0] CFG_RELEASE_SHIFT = 3'd3;
  localparam logic [2:0] CFG_MOD_REL_SHIFT = 3'd4;
  localparam logic [2:0] CFG_DEPTH_SHIFT  = 3'd5;

  // Register reset values
  localparam logic [15:0] CARRIER_INC_RST   = 16'd1044;
  localparam logic [15:0] MOD_INC_RST       = 16'd260;
  localparam logic [3:0]  ATTACK_SHIFT_RST  = 4'd0;
  localparam logic [3:0]  RELEASE_SHIFT_RST = 4'd4;
  localparam logic [3:0]  MOD_REL_SHIFT_RST = 4'd6;
  localparam logic [3:0]  DEPTH_SHIFT_RST   = 4'd7;

  localparam logic [15:0] ENV_FULL = 16'hFFFF;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL1,
    ST_MUL2
  } fmdv_state_e;

  // First quadrant of the sine, 127 * sin, truncated
  localparam logic [6:0] QUARTER_SINE [65] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,
    7'd24,  7'd27,  7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,
    7'd48,  7'd51,  7'd54,  7'd57,  7'd59,  7'd62,  7'd65,  7'd67,
    7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,  7'd85,  7'd87,
    7'd89,  7'd91,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd103,
    7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
    7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
    7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
    7'd127
  };

  // Full-cycle sine from the quarter table, signed -127..127
  function automatic logic signed [7:0] sine_at(input logic [7:0] idx);
    logic [6:0] h;
    logic [6:0] hm;
    logic [6:0] sel;
    logic [7:0] mag;
    h   = idx[6:0];
    hm  = 7'(8'd128 - {1'b0, h});
    sel = (h <= 7'd64) ? h : hm;
    mag = {1'b0, QUARTER_SINE[sel]};
    return idx[7] ? $signed(8'd0 - mag) : $signed(mag);
  endfunction

endpackage

FILE: hw/rtl/fmdv_serial_mul.sv
module fmdv_serial_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [8:0]  a_i,
  input  logic [7:0]         b_i,
  output logic               busy_o,
  output logic signed [16:0] p_o
);

  localparam int unsigned Steps = 8;

  logic [3:0]         cnt_q, cnt_d;
  logic signed [16:0] acc_q, acc_d;
  logic signed [16:0] a_sh_q, a_sh_d;
  logic [7:0]         b_q, b_d;

  // Take one multiplier bit per cycle, LSB first
  always_comb begin
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_sh_d = a_sh_q;
    b_d    = b_q;
    if (start_i) begin
      cnt_d  = 4'(Steps);
      acc_d  = '0;
      a_sh_d = 17'(a_i);
      b_d    = b_i;
    end else if (cnt_q != 4'd0) begin
      cnt_d  = cnt_q - 4'd1;
      acc_d  = b_q[0] ? (acc_q + a_sh_q) : acc_q;
      a_sh_d = a_sh_q <<< 1;
      b_d    = {1'b0, b_q[7:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    a_sh_q <= a_sh_d;
    b_q    <= b_d;
  end

  assign busy_o = (cnt_q != 4'd0);
  assign p_o    = acc_q;

endmodule

FILE: hw/rtl/fm_dds_voice_with_envelopes_unit.sv
// A request is taken only in the idle state; the next one waits until the sample is loaded.
// Each request runs two rounds of an 8-step bit-serial multiply (envelope product
// with the modulator in parallel, then the output scale). A finished sample waits in
// an output register, and the final round stalls while that register is still full.
// Reset: phases, envelopes and prescaler take their note-start values, the
// registers their defaults; no clearing pass, ready as soon as reset is released.
module fm_dds_voice_with_envelopes_unit import fmdv_pkg::*; #(
  parameter int unsigned DECAY_DIVIDER_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  sample_o
);

  // Configuration registers
  logic [15:0] carrier_inc_q, mod_inc_q;
  logic [3:0]  attack_shift_q, release_shift_q, mod_rel_shift_q, depth_shift_q;

  // Voice state
  logic [15:0] carrier_phase_q, carrier_phase_d;
  logic [15:0] mod_phase_q, mod_phase_d;
  logic [15:0] rise_env_q, rise_env_d;
  logic [15:0] fall_env_q, fall_env_d;
  logic [15:0] mod_env_q, mod_env_d;
  logic [DECAY_DIVIDER_BITS-1:0] prescaler_q, prescaler_d;

  fmdv_state_e state_q, state_d;

  logic        out_valid_q;
  logic [7:0]  sample_q;

  logic        accept;
  logic        load_sample;
  logic        start_a, start_b;
  logic        busy_a, busy_b;
  logic signed [8:0]  a_op;
  logic [7:0]         b_op;
  logic signed [16:0] prod_a, prod_b;
  logic signed [16:0] mod_full;
  logic [7:0]         car_idx;
  logic signed [7:0]  car_sine;
  logic signed [7:0]  mod_sine;
  logic [7:0]         amp;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_inc_q   <= CARRIER_INC_RST;
      mod_inc_q       <= MOD_INC_RST;
      attack_shift_q  <= ATTACK_SHIFT_RST;
      release_shift_q <= RELEASE_SHIFT_RST;
      mod_rel_shift_q <= MOD_REL_SHIFT_RST;
      depth_shift_q   <= DEPTH_SHIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CARRIER_INC:   carrier_inc_q   <= cfg_data_i;
        CFG_MOD_INC:       mod_inc_q       <= cfg_data_i;
        CFG_ATTACK_SHIFT:  attack_shift_q  <= cfg_data_i[3:0];
        CFG_RELEASE_SHIFT: release_shift_q <= cfg_data_i[3:0];
        CFG_MOD_REL_SHIFT: mod_rel_shift_q <= cfg_data_i[3:0];
        CFG_DEPTH_SHIFT:   depth_shift_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  // Advance phases and envelopes for one tick, after an optional note restart
  always_comb begin
    logic [15:0] cp, mp, re, fe, me;
    logic [DECAY_DIVIDER_BITS-1:0] ps;
    cp = restart_i ? 16'd0 : carrier_phase_q;
    mp = restart_i ? 16'd0 : mod_phase_q;
    re = restart_i ? ENV_FULL : rise_env_q;
    fe = restart_i ? ENV_FULL : fall_env_q;
    me = restart_i ? ENV_FULL : mod_env_q;
    ps = restart_i ? '0 : prescaler_q;
    carrier_phase_d = cp + carrier_inc_q;
    mod_phase_d     = mp + mod_inc_q;
    rise_env_d      = re;
    fall_env_d      = fe;
    mod_env_d       = me;
    if (ps == '0) begin
      rise_env_d = re - (re >> attack_shift_q);
      fall_env_d = fe - (fe >> release_shift_q);
      mod_env_d  = me - (me >> mod_rel_shift_q);
    end
    prescaler_d = ps + DECAY_DIVIDER_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_phase_q <= '0;
      mod_phase_q     <= '0;
      rise_env_q      <= ENV_FULL;
      fall_env_q      <= ENV_FULL;
      mod_env_q       <= ENV_FULL;
      prescaler_q     <= '0;
    end else if (accept) begin
      carrier_phase_q <= carrier_phase_d;
      mod_phase_q     <= mod_phase_d;
      rise_env_q      <= rise_env_d;
      fall_env_q      <= fall_env_d;
      mod_env_q       <= mod_env_d;
      prescaler_q     <= prescaler_d;
    end
  end

  // Carrier index from the modulator product, then the carrier sine
  assign amp      = prod_a[15:8];
  assign mod_full = prod_b >>> depth_shift_q;
  assign car_idx  = carrier_phase_q[15:8] + mod_full[7:0];
  assign car_sine = sine_at(car_idx);
  assign mod_sine = sine_at(mod_phase_q[15:8]);

  // Unit A: envelope product first, output scale second
  assign a_op = (state_q == ST_PREP) ? $signed({1'b0, ~rise_env_q[15:8]})
                                     : 9'(car_sine);
  assign b_op = (state_q == ST_PREP) ? fall_env_q[15:8] : amp;

  fmdv_serial_mul u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_a),
    .a_i     (a_op),
    .b_i     (b_op),
    .busy_o  (busy_a),
    .p_o     (prod_a)
  );

  // Unit B: modulator sine times modulation envelope
  fmdv_serial_mul u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_b),
    .a_i     (9'(mod_sine)),
    .b_i     (mod_env_q[15:8]),
    .busy_o  (busy_b),
    .p_o     (prod_b)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PREP;
      ST_PREP: state_d = ST_MUL1;
      ST_MUL1: if (!busy_a) state_d = ST_MUL2;
      ST_MUL2: if (!busy_a && (!out_valid_q || out_ready_i)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o  = 1'b0;
    start_a     = 1'b0;
    start_b     = 1'b0;
    load_sample = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_PREP: begin
        start_a = 1'b1;
        start_b = 1'b1;
      end
      ST_MUL1: start_a = !busy_a;
      ST_MUL2: load_sample = !busy_a && (!out_valid_q || out_ready_i);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the sample until the output side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_sample) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Recenter at 128: flip the sign bit of the scaled product
  always_ff @(posedge clk_i) begin
    if (load_sample) begin
      sample_q <= {~prod_a[15], prod_a[14:8]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

`ifndef SYNTHESIS
  a_rise_from_mul2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_MUL2))
    else $error("sample became valid outside the final multiply");

  a_units_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL1) |-> (busy_a == busy_b))
    else $error("multiply units out of step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_PREP))
    else $error("accepted request did not start a sample");

  a_amp_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL1 && !busy_a) |-> !prod_a[16])
    else $error("envelope product negative");
`endif

endmodule

FILE: tb/fm_dds_voice_with_envelopes_unit_tb.sv
module fm_dds_voice_with_envelopes_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fmdv_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int NOTE_ITEMS   = 60;
  localparam int NOTE_PHASES  = 8;
  localparam int MAX_REPORTS  = 10;

  // Unused register slots, writes there must be dropped
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  // Mirror of the voice: registers, note state and the samples still owed
  class fm_voice_scoreboard;
    logic [15:0] carrier_inc;
    logic [15:0] mod_inc;
    logic [3:0]  attack_sh;
    logic [3:0]  release_sh;
    logic [3:0]  mod_rel_sh;
    logic [3:0]  depth_sh;

    logic [15:0] carrier_ph;
    logic [15:0] mod_ph;
    logic [15:0] rise_env;
    logic [15:0] fall_env;
    logic [15:0] mod_env;
    logic [7:0]  prescaler;

    int          sine_lut [256];
    logic [7:0]  expected_samples [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      real two_pi;
      two_pi = 2.0 * 3.14159265358979323846;
      // S[i] = 127 * sin, truncated toward zero
      for (int i = 0; i < 256; i++) begin
        sine_lut[i] = $rtoi(127.0 * $sin(two_pi * i / 256.0));
      end
      carrier_inc = CARRIER_INC_RST;
      mod_inc     = MOD_INC_RST;
      attack_sh   = ATTACK_SHIFT_RST;
      release_sh  = RELEASE_SHIFT_RST;
      mod_rel_sh  = MOD_REL_SHIFT_RST;
      depth_sh    = DEPTH_SHIFT_RST;
      load_note_start();
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void load_note_start();
      carrier_ph = '0;
      mod_ph     = '0;
      rise_env   = ENV_FULL;
      fall_env   = ENV_FULL;
      mod_env    = ENV_FULL;
      prescaler  = '0;
    endfunction

    // Mask the write to the register width, drop unknown indexes
    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_CARRIER_INC:   carrier_inc = data;
        CFG_MOD_INC:       mod_inc     = data;
        CFG_ATTACK_SHIFT:  attack_sh   = data[3:0];
        CFG_RELEASE_SHIFT: release_sh  = data[3:0];
        CFG_MOD_REL_SHIFT: mod_rel_sh  = data[3:0];
        CFG_DEPTH_SHIFT:   depth_sh    = data[3:0];
        default: ;
      endcase
    endfunction

    // Advance one sample tick and return the sample it produces
    function logic [7:0] predict_sample(logic restart);
      int amp;
      int mod_term;
      int idx;
      int scaled;
      if (restart) load_note_start();
      carrier_ph += carrier_inc;
      mod_ph     += mod_inc;
      if (prescaler == '0) begin
        rise_env -= rise_env >> attack_sh;
        fall_env -= fall_env >> release_sh;
        mod_env  -= mod_env >> mod_rel_sh;
      end
      amp      = (int'(8'hFF - rise_env[15:8]) * int'(fall_env[15:8])) >> 8;
      mod_term = (sine_lut[mod_ph[15:8]] * int'(mod_env[15:8])) >>> depth_sh;
      idx      = (int'(carrier_ph[15:8]) + mod_term) & 255;
      scaled   = (amp * sine_lut[idx]) >>> 8;
      prescaler++;
      return 8'(128 + scaled);
    endfunction

    function void note_request(logic restart);
      expected_samples.push_back(predict_sample(restart));
    endfunction

    function void check_sample(logic [7:0] got);
      logic [7:0] want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] sample %0d arrived with no request pending", $time, got);
        end
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] sample #%0d: expected %0d, got %0d", $time, checked, want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        restart_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  sample_o;

  fm_voice_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int settings_run  = 1;
  int cycle_count   = 0;

  fm_dds_voice_with_envelopes_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the sample output at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Check samples first, then note accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_sample(sample_o);
      if (in_valid_i && in_ready_o) sb.note_request(restart_i);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d samples outstanding",
               cycle_count, sb.expected_samples.size());
      $display("FAIL");
      $finish;
    end
  end

  // Hold valid until the request is taken, with random idle cycles ahead of it
  task automatic send_request(logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every sample owed has come out
  task automatic drain_voice();
    in_valid_i <= 1'b0;
    while (sb.expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Keep the write enable high; the caller lowers it after the last write
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic write_all(logic [15:0] data);
    write_reg(CFG_CARRIER_INC, data);
    write_reg(CFG_MOD_INC, data);
    write_reg(CFG_ATTACK_SHIFT, data);
    write_reg(CFG_RELEASE_SHIFT, data);
    write_reg(CFG_MOD_REL_SHIFT, data);
    write_reg(CFG_DEPTH_SHIFT, data);
    write_reg(CFG_SPARE_LO, ~data);
    write_reg(CFG_SPARE_HI, ~data);
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  initial begin
    sb = new();
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_CARRIER_INC;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    restart_i  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default registers: note start, then a restart mid-note
    for (int i = 0; i < 8; i++) send_request(i == 0 || i == 5);
    drain_voice();

    // Every register at its top value, extra data bits set, spare slots hit
    write_all(16'hFFFF);
    for (int i = 0; i < 6; i++) send_request(i == 0 || i == 3);
    drain_voice();

    // Every register at zero: frozen phases, envelopes gone at once, full depth
    write_all(16'h0000);
    for (int i = 0; i < 6; i++) send_request(i == 0);
    drain_voice();

    // Long notes with random registers under each pacing mode
    for (int p = 0; p < NOTE_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      for (int r = 0; r < 8; r++) write_reg(3'(r), 16'($urandom));
      cfg_we_i <= 1'b0;
      settings_run++;
      for (int i = 0; i < NOTE_ITEMS; i++) send_request($urandom_range(99) < 2);
      drain_voice();
    end

    $display("Checked %0d samples across %0d register settings and four pacing modes,",
             sb.checked, settings_run);
    $display("with restarts, top and zero register values; %0d mismatches.", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
